FILE: hdl/mbb_pkg.sv
// Meter map bar/beat converter: shared types, constants and helpers.
// Used by every module of the block; no dependencies.
package mbb_pkg;
   localparam int SIG_POINTS = 8;
   localparam int REG_COUNT = 8;
   localparam int REG_SEL_W = $clog2(REG_COUNT);
   localparam int ADDR_W = REG_SEL_W + 2;
   localparam int PT_W = $clog2(SIG_POINTS + 1);
   localparam int PT_SEL_W = (SIG_POINTS > 1) ? $clog2(SIG_POINTS) : 1;
   localparam int SEG_DEPTH = SIG_POINTS + 1;
   localparam int SEG_IDX_W = $clog2(SEG_DEPTH);
   localparam int SEG_CNT_W = $clog2(SEG_DEPTH + 1);
   localparam int TPQ = 960;
   localparam int TICK_W = 48;
   localparam int ACC_W = 60;

   localparam logic [TICK_W-1:0] TICK_MAX = {1'b0, {(TICK_W-1){1'b1}}};
   localparam logic [31:0] SIG_POINT_0_RESET = 32'h8100_0001;
   localparam logic [30:0] BAR_MAX = {31{1'b1}};

   localparam logic [15:0] DEF_BAR = 16'd1;
   localparam logic [5:0] DEF_NUM = 6'd4;
   localparam logic [6:0] DEF_DEN = 7'd4;
   localparam logic [15:0] BEAT_DIVIDEND = 16'(TPQ * 4);

   localparam logic [1:0] FUNC_TICK_TO_BAR = 2'd0;
   localparam logic [1:0] FUNC_BAR_TO_TICK = 2'd1;
   localparam logic [1:0] FUNC_NEXT_BEAT = 2'd2;
   localparam logic [1:0] FUNC_SNAP = 2'd3;

   localparam logic [3:0] GRID_BAR = 4'd0;
   localparam logic [3:0] GRID_HALF = 4'd1;
   localparam logic [3:0] GRID_QUARTER = 4'd2;
   localparam logic [3:0] GRID_EIGHTH = 4'd3;
   localparam logic [3:0] GRID_16TH = 4'd4;
   localparam logic [3:0] GRID_32ND = 4'd5;
   localparam logic [3:0] GRID_QUARTER_TRIP = 4'd6;
   localparam logic [3:0] GRID_EIGHTH_TRIP = 4'd7;
   localparam logic [3:0] GRID_16TH_TRIP = 4'd8;

   typedef struct packed {
      logic [1:0] func;
      logic signed [47:0] tick_in;
      logic signed [31:0] bar_in;
      logic signed [15:0] beat_in;
      logic signed [31:0] offset_in_beat;
      logic [3:0] grid_code;
   } req_type;

   typedef struct packed {
      logic signed [47:0] tick_out;
      logic [30:0] bar_out;
      logic [6:0] beat_out;
      logic [15:0] tick_in_beat_out;
      logic is_downbeat;
      logic [15:0] beat_length;
      logic [23:0] bar_length;
   } rsp_type;

   typedef struct packed {
      logic [15:0] start_bar;
      logic [TICK_W-1:0] start_tick;
      logic [TICK_W-1:0] end_tick;
      logic [15:0] beat_ticks;
      logic [23:0] bar_ticks;
   } seg_type;

   typedef struct packed {
      logic [1:0] func;
      logic [TICK_W-1:0] tick;
      logic [30:0] bar;
      logic [14:0] beat;
      logic signed [31:0] offs;
      logic [3:0] grid;
      logic [SEG_IDX_W-1:0] seg;
      logic has_next;
   } item_type;

   function automatic logic [23:0] grid_step(input logic [3:0] code,
                                             input logic [23:0] bar_ticks);
      logic [23:0] step;
      unique case (code)
         GRID_BAR: step = bar_ticks;
         GRID_HALF: step = 24'(TPQ * 2);
         GRID_QUARTER: step = 24'(TPQ);
         GRID_EIGHTH: step = 24'(TPQ / 2);
         GRID_16TH: step = 24'(TPQ / 4);
         GRID_32ND: step = 24'(TPQ / 8);
         GRID_QUARTER_TRIP: step = 24'(TPQ * 2 / 3);
         GRID_EIGHTH_TRIP: step = 24'(TPQ / 3);
         GRID_16TH_TRIP: step = 24'(TPQ / 6);
         default: step = 24'(TPQ);
      endcase
      return step;
   endfunction
endpackage

FILE: hdl/mbb_seg_table.sv
// Signature point registers (APB) and the segment table built from them.
// Rebuilds serially after reset and after every write. Depends on mbb_pkg.
module mbb_seg_table (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [mbb_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   output mbb_pkg::seg_type [mbb_pkg::SEG_DEPTH-1:0] seg_tab,
   output logic [mbb_pkg::SEG_CNT_W-1:0] seg_count,
   output logic busy
);
   typedef enum logic [2:0] {B_CHECK, B_DIV, B_MUL, B_WRITE, B_DONE} bstate_type;

   logic [31:0] regs_ff [mbb_pkg::REG_COUNT];
   mbb_pkg::seg_type [mbb_pkg::SEG_DEPTH-1:0] seg_ff;
   bstate_type state_ff;
   logic [mbb_pkg::PT_W-1:0] pt_ff;
   logic [mbb_pkg::SEG_CNT_W-1:0] cnt_ff;
   logic [15:0] cand_bar_ff;
   logic [5:0] cand_num_ff;
   logic [6:0] cand_den_ff;
   logic dflt_ff;
   logic [15:0] dq_ff;
   logic [6:0] drem_ff;
   logic [4:0] dcnt_ff;
   logic [15:0] prev_bar_ff;
   logic [23:0] prev_bt_ff;
   logic [mbb_pkg::TICK_W-1:0] prev_start_ff;
   logic [15:0] beat_ff;
   logic [23:0] barticks_ff;
   logic [39:0] prod_ff;

   logic wr_en;
   logic [31:0] cur_reg;
   logic [15:0] cur_bar;
   logic skip;
   logic [7:0] rn;
   logic ge;
   logic [15:0] beat_in;
   logic [mbb_pkg::TICK_W-1:0] start_in;

   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = regs_ff[paddr[mbb_pkg::ADDR_W-1:2]];
   assign seg_tab = seg_ff;
   assign seg_count = cnt_ff;
   assign busy = (state_ff != B_DONE);

   always_comb begin
      cur_reg = regs_ff[pt_ff[mbb_pkg::PT_SEL_W-1:0]];
      cur_bar = cur_reg[15:0];
      skip = !cur_reg[31] || (cur_bar == 16'd0) || ((cnt_ff != '0) && (cur_bar < prev_bar_ff));
      rn = {drem_ff, dq_ff[15]};
      ge = (rn >= {1'b0, cand_den_ff});
      beat_in = (dq_ff == 16'd0) ? 16'd1 : dq_ff;
      start_in = prev_start_ff + mbb_pkg::TICK_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mbb_pkg::REG_COUNT; i++) begin
            regs_ff[i] <= (i == 0) ? mbb_pkg::SIG_POINT_0_RESET : 32'd0;
         end
         state_ff <= B_CHECK;
         pt_ff <= '0;
         cnt_ff <= '0;
         prev_bar_ff <= '0;
         prev_bt_ff <= '0;
         prev_start_ff <= '0;
      end else if (wr_en) begin
         regs_ff[paddr[mbb_pkg::ADDR_W-1:2]] <= pwdata;
         state_ff <= B_CHECK;
         pt_ff <= '0;
         cnt_ff <= '0;
         prev_bar_ff <= '0;
         prev_bt_ff <= '0;
         prev_start_ff <= '0;
      end else begin
         unique case (state_ff)
            B_CHECK: begin
               dq_ff <= mbb_pkg::BEAT_DIVIDEND;
               drem_ff <= '0;
               dcnt_ff <= 5'd16;
               if (pt_ff == mbb_pkg::PT_W'(mbb_pkg::SIG_POINTS)) begin
                  if (cnt_ff == '0) begin
                     cand_bar_ff <= mbb_pkg::DEF_BAR;
                     cand_num_ff <= mbb_pkg::DEF_NUM;
                     cand_den_ff <= mbb_pkg::DEF_DEN;
                     dflt_ff <= 1'b1;
                     state_ff <= B_DIV;
                  end else begin
                     state_ff <= B_DONE;
                  end
               end else if (skip) begin
                  pt_ff <= pt_ff + 1'b1;
               end else if ((cnt_ff == '0) && (cur_bar != 16'd1)) begin
                  cand_bar_ff <= mbb_pkg::DEF_BAR;
                  cand_num_ff <= mbb_pkg::DEF_NUM;
                  cand_den_ff <= mbb_pkg::DEF_DEN;
                  dflt_ff <= 1'b1;
                  state_ff <= B_DIV;
               end else begin
                  cand_bar_ff <= cur_bar;
                  cand_num_ff <= (cur_reg[21:16] == 6'd0) ? mbb_pkg::DEF_NUM : cur_reg[21:16];
                  cand_den_ff <= (cur_reg[28:22] == 7'd0) ? mbb_pkg::DEF_DEN : cur_reg[28:22];
                  dflt_ff <= 1'b0;
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               drem_ff <= ge ? 7'(rn - {1'b0, cand_den_ff}) : rn[6:0];
               dq_ff <= {dq_ff[14:0], ge};
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == 5'd1) begin
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               beat_ff <= beat_in;
               barticks_ff <= 24'(beat_in) * 24'(cand_num_ff);
               prod_ff <= prev_bt_ff * (cand_bar_ff - prev_bar_ff);
               state_ff <= B_WRITE;
            end
            B_WRITE: begin
               seg_ff[cnt_ff[mbb_pkg::SEG_IDX_W-1:0]] <=
                  {cand_bar_ff, start_in, mbb_pkg::TICK_MAX, beat_ff, barticks_ff};
               if (cnt_ff != '0) begin
                  seg_ff[mbb_pkg::SEG_IDX_W'(cnt_ff - 1'b1)].end_tick <= start_in;
               end
               prev_bar_ff <= cand_bar_ff;
               prev_bt_ff <= barticks_ff;
               prev_start_ff <= start_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (!dflt_ff) begin
                  pt_ff <= pt_ff + 1'b1;
               end
               state_ff <= B_CHECK;
            end
            B_DONE: begin
               state_ff <= B_DONE;
            end
            default: state_ff <= B_DONE;
         endcase
      end
   end
endmodule

FILE: hdl/mbb_front.sv
// Front end: accepts requests, clamps inputs and picks the segment.
// Depends on mbb_pkg; feeds mbb_queue.
module mbb_front (
   input  logic req_valid,
   output logic req_ready,
   input  mbb_pkg::req_type req_data,
   input  mbb_pkg::seg_type [mbb_pkg::SEG_DEPTH-1:0] seg_tab,
   input  logic [mbb_pkg::SEG_CNT_W-1:0] seg_count,
   input  logic busy,
   input  logic q_full,
   output logic push,
   output mbb_pkg::item_type push_item
);
   logic [mbb_pkg::TICK_W-1:0] tick_c;
   logic [30:0] bar_c;
   logic [14:0] beat_c;
   logic [mbb_pkg::SEG_IDX_W-1:0] seg_t;
   logic [mbb_pkg::SEG_IDX_W-1:0] seg_b;
   logic [mbb_pkg::SEG_IDX_W-1:0] seg_s;

   assign req_ready = !busy && !q_full;
   assign push = req_valid && req_ready;

   always_comb begin
      tick_c = req_data.tick_in[47] ? '0 : req_data.tick_in;
      bar_c = (req_data.bar_in < 32'sd1) ? 31'd1 : req_data.bar_in[30:0];
      beat_c = (req_data.beat_in < 16'sd1) ? 15'd1 : req_data.beat_in[14:0];
      seg_t = '0;
      seg_b = '0;
      for (int i = 1; i < mbb_pkg::SEG_DEPTH; i++) begin
         if (mbb_pkg::SEG_CNT_W'(i) < seg_count) begin
            if (seg_tab[i].start_tick <= tick_c) seg_t = mbb_pkg::SEG_IDX_W'(i);
            if ({15'd0, seg_tab[i].start_bar} <= bar_c) seg_b = mbb_pkg::SEG_IDX_W'(i);
         end
      end
      seg_s = (req_data.func == mbb_pkg::FUNC_BAR_TO_TICK) ? seg_b : seg_t;
      push_item.func = req_data.func;
      push_item.tick = tick_c;
      push_item.bar = bar_c;
      push_item.beat = beat_c;
      push_item.offs = req_data.offset_in_beat;
      push_item.grid = req_data.grid_code;
      push_item.seg = seg_s;
      push_item.has_next = (mbb_pkg::SEG_CNT_W'(seg_s) + 1'b1) < seg_count;
   end
endmodule

FILE: hdl/mbb_queue.sv
// Two-entry queue between front and back end. Depends on mbb_pkg.
module mbb_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  mbb_pkg::item_type push_item,
   output logic full,
   input  logic pop,
   output logic pop_valid,
   output mbb_pkg::item_type pop_item
);
   mbb_pkg::item_type mem_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            mem_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

FILE: hdl/mbb_back.sv
// Back end: serial divider, multiply-add sequence and result register.
// Depends on mbb_pkg; takes items from mbb_queue.
module mbb_back (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   input  mbb_pkg::item_type pop_item,
   output logic pop,
   input  mbb_pkg::seg_type [mbb_pkg::SEG_DEPTH-1:0] seg_tab,
   output logic rsp_valid,
   input  logic rsp_ready,
   output mbb_pkg::rsp_type rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_DIV, S_BEAT, S_MUL_LO, S_MUL_HI, S_MUL_BEAT,
      S_ADD_OFFS, S_FIN, S_OUT
   } state_type;

   localparam logic signed [mbb_pkg::ACC_W-1:0] ACC_MAX =
      mbb_pkg::ACC_W'(mbb_pkg::TICK_MAX);
   localparam logic signed [mbb_pkg::ACC_W-1:0] ACC_MIN = -ACC_MAX - 1;

   state_type state_ff;
   mbb_pkg::item_type item_ff;
   mbb_pkg::seg_type seg_ff;
   logic [mbb_pkg::TICK_W-1:0] dvd_ff;
   logic [23:0] rem_ff;
   logic [23:0] dsr_ff;
   logic [5:0] dcnt_ff;
   logic sec_ff;
   logic [23:0] step_ff;
   logic [30:0] diff_ff;
   logic [30:0] bar_res_ff;
   logic signed [mbb_pkg::ACC_W-1:0] acc_ff;
   mbb_pkg::rsp_type res_ff;
   mbb_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic [mbb_pkg::TICK_W-1:0] off;
   logic [23:0] step;
   logic [24:0] rn;
   logic ge;
   logic [48:0] bar_sum;
   logic [48:0] next_r;
   logic [48:0] snap_r;
   logic [39:0] prod_lo;
   logic [38:0] prod_hi;
   logic [30:0] prod_beat;
   mbb_pkg::rsp_type res_in;

   assign pop = (state_ff == S_IDLE) && pop_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      off = item_ff.tick - seg_ff.start_tick;
      step = mbb_pkg::grid_step(item_ff.grid, seg_ff.bar_ticks);
      rn = {rem_ff, dvd_ff[mbb_pkg::TICK_W-1]};
      ge = (rn >= {1'b0, dsr_ff});
      bar_sum = 49'(seg_ff.start_bar) + 49'(dvd_ff);
      next_r = 49'(item_ff.tick) + 49'(seg_ff.beat_ticks) - 49'd1 - 49'(rem_ff);
      if (item_ff.has_next && (next_r > 49'(seg_ff.end_tick))) next_r = 49'(seg_ff.end_tick);
      snap_r = 49'(item_ff.tick) + 49'(step_ff[23:1]) - 49'(rem_ff);
      prod_lo = diff_ff[15:0] * seg_ff.bar_ticks;
      prod_hi = diff_ff[30:16] * seg_ff.bar_ticks;
      prod_beat = (item_ff.beat - 15'd1) * seg_ff.beat_ticks;

      res_in = '0;
      res_in.beat_length = seg_ff.beat_ticks;
      res_in.bar_length = seg_ff.bar_ticks;
      unique case (item_ff.func)
         mbb_pkg::FUNC_TICK_TO_BAR: begin
            res_in.bar_out = bar_res_ff;
            res_in.beat_out = dvd_ff[6:0] + 7'd1;
            res_in.tick_in_beat_out = rem_ff[15:0];
            res_in.is_downbeat = (dvd_ff == '0) && (rem_ff == '0);
         end
         mbb_pkg::FUNC_BAR_TO_TICK: begin
            if (acc_ff > ACC_MAX) res_in.tick_out = mbb_pkg::TICK_MAX;
            else if (acc_ff < ACC_MIN) res_in.tick_out = ~mbb_pkg::TICK_MAX;
            else res_in.tick_out = acc_ff[mbb_pkg::TICK_W-1:0];
         end
         mbb_pkg::FUNC_NEXT_BEAT: begin
            if (item_ff.tick == '0) res_in.tick_out = '0;
            else if (next_r > 49'(mbb_pkg::TICK_MAX)) res_in.tick_out = mbb_pkg::TICK_MAX;
            else res_in.tick_out = next_r[mbb_pkg::TICK_W-1:0];
         end
         mbb_pkg::FUNC_SNAP: begin
            if (snap_r > 49'(mbb_pkg::TICK_MAX)) res_in.tick_out = mbb_pkg::TICK_MAX;
            else res_in.tick_out = snap_r[mbb_pkg::TICK_W-1:0];
         end
         default: res_in.tick_out = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_OUT) || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  item_ff <= pop_item;
                  seg_ff <= seg_tab[pop_item.seg];
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               rem_ff <= '0;
               sec_ff <= 1'b0;
               dcnt_ff <= 6'(mbb_pkg::TICK_W);
               diff_ff <= item_ff.bar - 31'(seg_ff.start_bar);
               step_ff <= step;
               unique case (item_ff.func)
                  mbb_pkg::FUNC_TICK_TO_BAR: begin
                     dvd_ff <= off;
                     dsr_ff <= seg_ff.bar_ticks;
                     state_ff <= S_DIV;
                  end
                  mbb_pkg::FUNC_BAR_TO_TICK: state_ff <= S_MUL_LO;
                  mbb_pkg::FUNC_NEXT_BEAT: begin
                     dvd_ff <= off + mbb_pkg::TICK_W'(seg_ff.beat_ticks) - 1'b1;
                     dsr_ff <= 24'(seg_ff.beat_ticks);
                     state_ff <= (item_ff.tick == '0) ? S_FIN : S_DIV;
                  end
                  mbb_pkg::FUNC_SNAP: begin
                     dvd_ff <= off + mbb_pkg::TICK_W'(step[23:1]);
                     dsr_ff <= step;
                     state_ff <= S_DIV;
                  end
                  default: state_ff <= S_FIN;
               endcase
            end
            S_DIV: begin
               rem_ff <= ge ? 24'(rn - {1'b0, dsr_ff}) : rn[23:0];
               dvd_ff <= {dvd_ff[mbb_pkg::TICK_W-2:0], ge};
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == 6'd1) begin
                  state_ff <= ((item_ff.func == mbb_pkg::FUNC_TICK_TO_BAR) && !sec_ff) ?
                              S_BEAT : S_FIN;
               end
            end
            S_BEAT: begin
               bar_res_ff <= (bar_sum > 49'(mbb_pkg::BAR_MAX)) ? mbb_pkg::BAR_MAX :
                             bar_sum[30:0];
               dvd_ff <= {rem_ff, 24'd0};
               dsr_ff <= 24'(seg_ff.beat_ticks);
               rem_ff <= '0;
               dcnt_ff <= 6'd24;
               sec_ff <= 1'b1;
               state_ff <= S_DIV;
            end
            S_MUL_LO: begin
               acc_ff <= mbb_pkg::ACC_W'(seg_ff.start_tick) + mbb_pkg::ACC_W'(prod_lo);
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               acc_ff <= acc_ff + (mbb_pkg::ACC_W'(prod_hi) << 16);
               state_ff <= S_MUL_BEAT;
            end
            S_MUL_BEAT: begin
               acc_ff <= acc_ff + mbb_pkg::ACC_W'(prod_beat);
               state_ff <= S_ADD_OFFS;
            end
            S_ADD_OFFS: begin
               acc_ff <= acc_ff + mbb_pkg::ACC_W'(item_ff.offs);
               state_ff <= S_FIN;
            end
            S_FIN: begin
               res_ff <= res_in;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: hdl/meter_map_bar_beat_converter.sv
// Path from request accept to rsp_valid: front end, two-entry queue, then the back
// end (next beat at tick 0 goes straight to the result; bar/beat to tick runs the
// multiply-add sequence; next beat and snap run the 48-step divider; tick to bar runs
// the 48-step plus 24-step serial divider). One request in the back end at a time;
// a two-entry queue keeps accepting while it works. Reset: registers reload, then the
// segment table rebuilds (and again after every register write) while req_ready is low.
module meter_map_bar_beat_converter (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  mbb_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output mbb_pkg::rsp_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [mbb_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   mbb_pkg::seg_type [mbb_pkg::SEG_DEPTH-1:0] seg_tab;
   logic [mbb_pkg::SEG_CNT_W-1:0] seg_count;
   logic busy;
   logic q_full;
   logic push;
   mbb_pkg::item_type push_item;
   logic pop;
   logic pop_valid;
   mbb_pkg::item_type pop_item;

   mbb_seg_table u_table (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .seg_tab(seg_tab), .seg_count(seg_count), .busy(busy)
   );

   mbb_front u_front (
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .seg_tab(seg_tab), .seg_count(seg_count), .busy(busy), .q_full(q_full),
      .push(push), .push_item(push_item)
   );

   mbb_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item), .full(q_full),
      .pop(pop), .pop_valid(pop_valid), .pop_item(pop_item)
   );

   mbb_back u_back (
      .clock(clock), .reset(reset), .pop_valid(pop_valid), .pop_item(pop_item),
      .pop(pop), .seg_tab(seg_tab), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (seg_count >= mbb_pkg::SEG_CNT_W'(1)) &&
                (seg_count <= mbb_pkg::SEG_CNT_W'(mbb_pkg::SEG_DEPTH)))
      else $error("segment count out of range");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("request accepted during table rebuild");

   a_downbeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_downbeat |->
         (rsp_data.beat_out == 7'd1) && (rsp_data.tick_in_beat_out == 16'd0))
      else $error("downbeat flag inconsistent");
endmodule

FILE: verif/testbench.sv
// Testbench for meter_map_bar_beat_converter: directed and random conversion requests
// checked against an in-bench meter map predictor held in a scoreboard class.
// Depends on mbb_pkg and the block RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint TMAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint TMIN = -TMAX - 1;

   class meter_scoreboard;
      logic [31:0] sig_reg[mbb_pkg::REG_COUNT];
      longint seg_bar[mbb_pkg::SEG_DEPTH];
      longint seg_tick[mbb_pkg::SEG_DEPTH];
      longint seg_end[mbb_pkg::SEG_DEPTH];
      longint seg_beat[mbb_pkg::SEG_DEPTH];
      longint seg_len[mbb_pkg::SEG_DEPTH];
      int seg_cnt;
      mbb_pkg::rsp_type pending[$];
      int errors;
      int checked;

      function void add_seg(longint b, longint n, longint d);
         longint bt;
         if (seg_cnt >= mbb_pkg::SEG_DEPTH) return;
         if (n == 0) n = 4;
         if (d == 0) d = 4;
         bt = (mbb_pkg::TPQ * 4) / d;
         if (bt == 0) bt = 1;
         seg_bar[seg_cnt] = b;
         seg_beat[seg_cnt] = bt;
         seg_len[seg_cnt] = bt * n;
         seg_cnt++;
      endfunction

      function void rebuild_map();
         longint last;
         longint b;
         longint t;
         bit any;
         last = 0;
         any = 0;
         t = 0;
         seg_cnt = 0;
         for (int i = 0; i < mbb_pkg::SIG_POINTS; i++) begin
            b = longint'(sig_reg[i][15:0]);
            if (!sig_reg[i][31] || b == 0) continue;
            if (any && b < last) continue;
            if (!any && b != 1) add_seg(1, 4, 4);
            add_seg(b, longint'(sig_reg[i][21:16]), longint'(sig_reg[i][28:22]));
            last = b;
            any = 1;
         end
         if (!any) add_seg(1, 4, 4);
         for (int i = 0; i < seg_cnt; i++) begin
            seg_tick[i] = t;
            if (i + 1 < seg_cnt) begin
               t += seg_len[i] * (seg_bar[i+1] - seg_bar[i]);
               seg_end[i] = t;
            end else begin
               seg_end[i] = TMAX;
            end
         end
      endfunction

      function void reset_map();
         foreach (sig_reg[i]) sig_reg[i] = 0;
         sig_reg[0] = mbb_pkg::SIG_POINT_0_RESET;
         pending.delete();
         rebuild_map();
      endfunction

      function void write_reg(int idx, logic [31:0] v);
         sig_reg[idx] = v;
         rebuild_map();
      endfunction

      function longint sat(longint t);
         if (t > TMAX) return TMAX;
         if (t < TMIN) return TMIN;
         return t;
      endfunction

      function longint step_of(logic [3:0] g, int s);
         case (g)
            mbb_pkg::GRID_BAR: return seg_len[s];
            mbb_pkg::GRID_HALF: return mbb_pkg::TPQ * 2;
            mbb_pkg::GRID_QUARTER: return mbb_pkg::TPQ;
            mbb_pkg::GRID_EIGHTH: return mbb_pkg::TPQ / 2;
            mbb_pkg::GRID_16TH: return mbb_pkg::TPQ / 4;
            mbb_pkg::GRID_32ND: return mbb_pkg::TPQ / 8;
            mbb_pkg::GRID_QUARTER_TRIP: return mbb_pkg::TPQ * 2 / 3;
            mbb_pkg::GRID_EIGHTH_TRIP: return mbb_pkg::TPQ / 3;
            mbb_pkg::GRID_16TH_TRIP: return mbb_pkg::TPQ / 6;
            default: return mbb_pkg::TPQ;
         endcase
      endfunction

      function void note_request(mbb_pkg::req_type q);
         mbb_pkg::rsp_type r;
         longint tk, br, bt, off, bl, inb, res, stp;
         int s;
         r = '0;
         tk = longint'(q.tick_in);
         if (tk < 0) tk = 0;
         s = 0;
         if (q.func == mbb_pkg::FUNC_BAR_TO_TICK) begin
            br = longint'(q.bar_in);
            bt = longint'(q.beat_in);
            if (br < 1) br = 1;
            if (bt < 1) bt = 1;
            for (int i = 1; i < seg_cnt; i++) if (seg_bar[i] <= br) s = i;
            r.tick_out = 48'(sat(seg_tick[s] + (br - seg_bar[s]) * seg_len[s]
                                 + (bt - 1) * seg_beat[s] + longint'(q.offset_in_beat)));
         end else begin
            for (int i = 1; i < seg_cnt; i++) if (seg_tick[i] <= tk) s = i;
            bt = seg_beat[s];
            off = tk - seg_tick[s];
            if (q.func == mbb_pkg::FUNC_TICK_TO_BAR) begin
               bl = seg_len[s];
               inb = off % bl;
               br = seg_bar[s] + off / bl;
               if (br > 2147483647) br = 2147483647;
               r.bar_out = 31'(br);
               r.beat_out = 7'(inb / bt + 1);
               r.tick_in_beat_out = 16'(inb % bt);
               r.is_downbeat = (inb / bt == 0) && (inb % bt == 0);
            end else if (q.func == mbb_pkg::FUNC_NEXT_BEAT) begin
               if (tk > 0) begin
                  res = seg_tick[s] + ((off + bt - 1) / bt) * bt;
                  if (s + 1 < seg_cnt && res > seg_end[s]) res = seg_end[s];
                  r.tick_out = 48'(sat(res));
               end
            end else begin
               stp = step_of(q.grid_code, s);
               if (stp <= 0) r.tick_out = 48'(sat(tk));
               else r.tick_out = 48'(sat(seg_tick[s] + ((off + stp / 2) / stp) * stp));
            end
         end
         r.beat_length = 16'(seg_beat[s]);
         r.bar_length = 24'(seg_len[s]);
         pending = {pending, r};
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
         $display("MISMATCH %s: got %h expected %h (response %0d)", what, got, exp, checked);
         errors++;
      endtask

      task check_response(mbb_pkg::rsp_type got);
         mbb_pkg::rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch("response with nothing pending", 64'd0, 64'd0);
            return;
         end
         e = pending.pop_front();
         if (got.tick_out !== e.tick_out)
            report_mismatch("tick_out", 64'(got.tick_out), 64'(e.tick_out));
         if (got.bar_out !== e.bar_out)
            report_mismatch("bar_out", 64'(got.bar_out), 64'(e.bar_out));
         if (got.beat_out !== e.beat_out)
            report_mismatch("beat_out", 64'(got.beat_out), 64'(e.beat_out));
         if (got.tick_in_beat_out !== e.tick_in_beat_out)
            report_mismatch("tick_in_beat_out", 64'(got.tick_in_beat_out),
                            64'(e.tick_in_beat_out));
         if (got.is_downbeat !== e.is_downbeat)
            report_mismatch("is_downbeat", 64'(got.is_downbeat), 64'(e.is_downbeat));
         if (got.beat_length !== e.beat_length)
            report_mismatch("beat_length", 64'(got.beat_length), 64'(e.beat_length));
         if (got.bar_length !== e.bar_length)
            report_mismatch("bar_length", 64'(got.bar_length), 64'(e.bar_length));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   mbb_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   mbb_pkg::rsp_type rsp_data;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [mbb_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   meter_scoreboard sb;
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_off = 0;
   int quiet = 0;
   int sent = 0;

   always #4 clock = ~clock;

   meter_map_bar_beat_converter DUT (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) quiet = 0;
         else quiet++;
         if (quiet > 20000) begin
            $display("timeout: no activity");
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic write_csr(int idx, logic [31:0] v);
      @(negedge clock);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= mbb_pkg::ADDR_W'(idx * 4);
      pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      sb.write_reg(idx, v);
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic send_request(mbb_pkg::req_type q);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_send_idle(int s, int r);
      send_idle = s;
      recv_idle = r;
   endtask

   function automatic logic [31:0] sig_word(int b, int n, int d, bit en);
      return {en, 2'b00, 7'(d), 6'(n), 16'(b)};
   endfunction

   function automatic mbb_pkg::req_type rand_request();
      mbb_pkg::req_type q;
      q.func = 2'($urandom_range(3));
      case ($urandom_range(5))
         0: q.tick_in = 48'({$urandom, $urandom});
         1: q.tick_in = -$signed(48'($urandom_range(5000)));
         default: q.tick_in = 48'($urandom_range(400000));
      endcase
      case ($urandom_range(4))
         0: q.bar_in = $urandom;
         1: q.bar_in = -$signed(32'($urandom_range(3)));
         default: q.bar_in = $urandom_range(200);
      endcase
      q.beat_in = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(12));
      q.offset_in_beat = ($urandom_range(3) == 0) ? $urandom
                         : 32'($signed($urandom_range(4000)) - 2000);
      q.grid_code = 4'($urandom_range(15));
      return q;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_request(rand_request());
   endtask

   initial begin
      mbb_pkg::req_type q;
      sb = new();
      sb.reset_map();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset map, field extremes, all functions and grids
      for (int f = 0; f < 4; f++) begin
         q = '0;
         q.func = 2'(f);
         q.tick_in = 48'h7FFF_FFFF_FFFF;
         q.bar_in = 32'h7FFF_FFFF;
         q.beat_in = 16'h7FFF;
         q.offset_in_beat = 32'h7FFF_FFFF;
         send_request(q);
         q.tick_in = 48'h8000_0000_0000;
         q.bar_in = 32'h8000_0000;
         q.beat_in = 16'h8000;
         q.offset_in_beat = 32'h8000_0000;
         send_request(q);
      end
      for (int g = 0; g < 16; g += 1) begin
         q = '0;
         q.func = mbb_pkg::FUNC_SNAP;
         q.grid_code = 4'(g);
         q.tick_in = 48'(1000 + g * 37);
         send_request(q);
      end
      drain();

      // missing bar one, zero fields, out of order, equal bars, huge denominator
      write_csr(0, sig_word(5, 3, 4, 1));
      write_csr(1, sig_word(9, 0, 0, 1));
      write_csr(2, sig_word(7, 5, 8, 1));
      write_csr(3, sig_word(12, 7, 8, 1));
      write_csr(4, sig_word(12, 6, 16, 1));
      write_csr(5, sig_word(0, 2, 2, 1));
      write_csr(6, sig_word(20, 63, 127, 1));
      write_csr(7, sig_word(30, 2, 4, 0));
      send_send_idle(24, 51);
      random_phase(150);
      drain();

      write_csr(0, 32'hFFFF_FFFF);
      write_csr(1, sig_word(65535, 63, 1, 1));
      write_csr(6, 32'h0);
      send_send_idle(51, 24);
      random_phase(150);

      // long receiver stall so the block fills and backs up
      hold_off = 1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         random_phase(8);
      join
      drain();

      write_csr(0, sig_word(1, 3, 4, 1));
      write_csr(1, sig_word(3, 7, 8, 1));
      write_csr(2, sig_word(6, 2, 2, 1));
      write_csr(3, sig_word(10, 5, 16, 1));
      write_csr(4, sig_word(11, 9, 32, 1));
      write_csr(5, sig_word(15, 4, 4, 1));
      write_csr(6, sig_word(18, 1, 1, 1));
      write_csr(7, sig_word(25, 12, 8, 1));
      send_send_idle(0, 0);
      random_phase(150);
      drain();

      $display("covered %0d requests, %0d responses over four signature maps",
               sent, sb.checked);
      $display("including extreme fields, every grid code and a long receiver stall");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule

FILE: filelist.f
hdl/mbb_pkg.sv
hdl/mbb_seg_table.sv
hdl/mbb_front.sv
hdl/mbb_queue.sv
hdl/mbb_back.sv
hdl/meter_map_bar_beat_converter.sv
verif/testbench.sv
